>>> src/assert_macros.svh
// assertion macros used by the rtl of vector_plane_rotation_top
// clocked on clk, disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define VPR_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define VPR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/vpr_pkg.sv
// constants, types and the cordic arctangent table for the plane rotation block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package vpr_pkg;

    localparam int DATA_WIDTH    = 32;
    localparam int ANGLE_WIDTH   = 16;
    localparam int CORDIC_STAGES = 16;

    localparam int PLANE_W = 2;
    localparam int AXES    = 3;

    // cordic angle path in 32-bit binary angle units, x and y in q1.30
    localparam int BAM_W  = 32;
    localparam int ZW     = BAM_W + 1;
    localparam int CW     = BAM_W + 2;
    localparam int COEF_W = 32;
    localparam int FRAC_W = 30;

    localparam logic signed [COEF_W-1:0] INV_GAIN = 32'sh26DD3B6A;

    localparam int IN_FIELDS_W  = AXES * DATA_WIDTH + PLANE_W + ANGLE_WIDTH;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = AXES * DATA_WIDTH;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [PLANE_W-1:0] PLANE_XY    = 2'd0;
    localparam logic [PLANE_W-1:0] PLANE_YZ    = 2'd1;
    localparam logic [PLANE_W-1:0] PLANE_ZX    = 2'd2;
    localparam logic [PLANE_W-1:0] PLANE_ALIAS = 2'd3;

    typedef logic signed [DATA_WIDTH-1:0] data_t;
    typedef logic [PLANE_W-1:0] plane_t;

    // atan(2^-i) in 32-bit binary angle units
    function automatic logic signed [BAM_W-1:0] atan_entry(input int idx);
        logic signed [BAM_W-1:0] val;
        begin
            unique case (idx)
                0:       val = 32'sh20000000;
                1:       val = 32'sh12E4051E;
                2:       val = 32'sh09FB385B;
                3:       val = 32'sh051111D4;
                4:       val = 32'sh028B0D43;
                5:       val = 32'sh0145D7E1;
                6:       val = 32'sh00A2F61E;
                7:       val = 32'sh00517C55;
                8:       val = 32'sh0028BE53;
                9:       val = 32'sh00145F2F;
                10:      val = 32'sh000A2F98;
                11:      val = 32'sh000517CC;
                12:      val = 32'sh00028BE6;
                13:      val = 32'sh000145F3;
                14:      val = 32'sh0000A2FA;
                15:      val = 32'sh0000517D;
                16:      val = 32'sh000028BE;
                17:      val = 32'sh0000145F;
                18:      val = 32'sh00000A30;
                19:      val = 32'sh00000518;
                20:      val = 32'sh0000028C;
                21:      val = 32'sh00000146;
                22:      val = 32'sh000000A3;
                23:      val = 32'sh00000051;
                default: val = '0;
            endcase
            return val;
        end
    endfunction

endpackage

`default_nettype wire

>>> src/vector_plane_rotation_top.sv
// Rotates a signed q16.16 vector (x,y,z) by a binary angle inside the plane chosen by
// plane_sel (0 or 3: x,y  1: y,z  2: z,x) using a gain-compensated
// cordic; rotated components are rounded half up and saturated, the third passes through.
// One beat is taken per clock while the output is not stalled; a beat passes the input register, one
// register per cordic micro-rotation, then the coefficient, multiply, sum and saturate registers.
// Every stage carries its own valid bit, so bubbles close up while m_tready is low.
// Depends on vpr_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module vector_plane_rotation_top
    import vpr_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // comp_x, comp_y, comp_z, plane_sel, turn_angle, zero pad
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // rot_x, rot_y, rot_z
    output logic [OUT_TDATA_W-1:0]      m_tdata
);

    localparam int ST_C = CORDIC_STAGES + 1;
    localparam int ST_M = CORDIC_STAGES + 2;
    localparam int ST_S = CORDIC_STAGES + 3;
    localparam int ST_O = CORDIC_STAGES + 4;
    localparam int NST  = CORDIC_STAGES + 5;

    localparam int PW = COEF_W + DATA_WIDTH;
    localparam int SW = PW + 1;
    localparam int RW = SW - FRAC_W;

    localparam logic signed [ZW-1:0] QUARTER     = ZW'(1) <<< (BAM_W - 2);
    localparam logic signed [ZW-1:0] NEG_QUARTER = -QUARTER;
    localparam logic signed [ZW-1:0] HALF_TURN   = ZW'(1) <<< (BAM_W - 1);
    localparam logic signed [SW-1:0] RND_HALF    = SW'(1) <<< (FRAC_W - 1);
    localparam logic signed [RW-1:0] SAT_HI      =
        signed'({{(RW - DATA_WIDTH + 1){1'b0}}, {(DATA_WIDTH - 1){1'b1}}});
    localparam logic signed [RW-1:0] SAT_LO      = -SAT_HI - RW'(1);

    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_next;
    logic [NST-1:0] adv;

    logic signed [CW-1:0] x_reg [0:CORDIC_STAGES];
    logic signed [CW-1:0] y_reg [0:CORDIC_STAGES];
    logic signed [ZW-1:0] z_reg [0:CORDIC_STAGES];
    logic                 flip_reg [0:CORDIC_STAGES];
    data_t                first_reg [0:ST_C];
    data_t                second_reg [0:ST_C];
    data_t                third_reg [0:ST_S];
    plane_t               plane_reg [0:ST_S];

    logic signed [COEF_W-1:0] cs_reg, sn_reg, nsn_reg;
    logic signed [COEF_W-1:0] cs_next, sn_next, nsn_next;
    logic signed [PW-1:0]     p11_reg, p12_reg, p21_reg, p22_reg;
    logic signed [SW-1:0]     sum1_reg, sum2_reg;
    data_t                    rot_x_reg, rot_y_reg, rot_z_reg;
    data_t                    rot_x_next, rot_y_next, rot_z_next;

    // input fields
    data_t                   comp_x, comp_y, comp_z;
    plane_t                  plane_sel, plane_red;
    logic signed [ANGLE_WIDTH-1:0] turn_angle;
    logic signed [ZW-1:0]    z_wide, z0_next;
    logic                    flip0_next;
    data_t                   first0_next, second0_next, third0_next;

    assign comp_x     = s_tdata[0 +: DATA_WIDTH];
    assign comp_y     = s_tdata[DATA_WIDTH +: DATA_WIDTH];
    assign comp_z     = s_tdata[2 * DATA_WIDTH +: DATA_WIDTH];
    assign plane_sel  = s_tdata[AXES * DATA_WIDTH +: PLANE_W];
    assign turn_angle = s_tdata[AXES * DATA_WIDTH + PLANE_W +: ANGLE_WIDTH];

    // handshake: a stage moves when empty or when the stage after it moves
    always_comb
    begin
        adv[NST-1] = !vld_reg[NST-1] || m_tready;
        for (int k = NST - 2; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
        vld_next[0] = adv[0] ? s_tvalid : vld_reg[0];
        for (int k = 1; k < NST; k++)
        begin
            vld_next[k] = adv[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    assign s_tready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // input stage: plane alias, angle folding into +-pi/2
    always_comb
    begin
        plane_red  = (plane_sel == PLANE_ALIAS) ? PLANE_XY : plane_sel;
        z_wide     = ZW'(signed'({turn_angle, {(BAM_W - ANGLE_WIDTH){1'b0}}}));
        z0_next    = z_wide;
        flip0_next = 1'b0;
        if (z_wide > QUARTER)
        begin
            z0_next    = z_wide - HALF_TURN;
            flip0_next = 1'b1;
        end
        else if (z_wide < NEG_QUARTER)
        begin
            z0_next    = z_wide + HALF_TURN;
            flip0_next = 1'b1;
        end
        unique case (plane_red)
            PLANE_XY:
            begin
                first0_next  = comp_x;
                second0_next = comp_y;
                third0_next  = comp_z;
            end
            PLANE_YZ:
            begin
                first0_next  = comp_y;
                second0_next = comp_z;
                third0_next  = comp_x;
            end
            default:
            begin
                first0_next  = comp_z;
                second0_next = comp_x;
                third0_next  = comp_y;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            x_reg[0]      <= CW'(INV_GAIN);
            y_reg[0]      <= '0;
            z_reg[0]      <= z0_next;
            flip_reg[0]   <= flip0_next;
            first_reg[0]  <= first0_next;
            second_reg[0] <= second0_next;
            third_reg[0]  <= third0_next;
            plane_reg[0]  <= plane_red;
        end
    end

    // cordic micro-rotations, one register stage each
    for (genvar k = 0; k < CORDIC_STAGES; k++)
    begin : g_cordic
        localparam logic signed [ZW-1:0] ATAN_K = ZW'(atan_entry(k));
        logic signed [CW-1:0] x_next, y_next;
        logic signed [ZW-1:0] z_next;

        always_comb
        begin
            if (z_reg[k] >= 0)
            begin
                x_next = x_reg[k] - (y_reg[k] >>> k);
                y_next = y_reg[k] + (x_reg[k] >>> k);
                z_next = z_reg[k] - ATAN_K;
            end
            else
            begin
                x_next = x_reg[k] + (y_reg[k] >>> k);
                y_next = y_reg[k] - (x_reg[k] >>> k);
                z_next = z_reg[k] + ATAN_K;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv[k+1])
            begin
                x_reg[k+1]    <= x_next;
                y_reg[k+1]    <= y_next;
                z_reg[k+1]    <= z_next;
                flip_reg[k+1] <= flip_reg[k];
            end
        end
    end

    for (genvar k = 1; k <= ST_C; k++)
    begin : g_pair
        always_ff @(posedge clk)
        begin
            if (adv[k])
            begin
                first_reg[k]  <= first_reg[k-1];
                second_reg[k] <= second_reg[k-1];
            end
        end
    end

    for (genvar k = 1; k <= ST_S; k++)
    begin : g_pass
        always_ff @(posedge clk)
        begin
            if (adv[k])
            begin
                third_reg[k] <= third_reg[k-1];
                plane_reg[k] <= plane_reg[k-1];
            end
        end
    end

    // coefficient stage: undo the half-turn fold
    always_comb
    begin
        if (flip_reg[CORDIC_STAGES])
        begin
            cs_next = COEF_W'(-x_reg[CORDIC_STAGES]);
            sn_next = COEF_W'(-y_reg[CORDIC_STAGES]);
        end
        else
        begin
            cs_next = COEF_W'(x_reg[CORDIC_STAGES]);
            sn_next = COEF_W'(y_reg[CORDIC_STAGES]);
        end
        nsn_next = -sn_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv[ST_C])
        begin
            cs_reg  <= cs_next;
            sn_reg  <= sn_next;
            nsn_reg <= nsn_next;
        end
    end

    // multiply stage
    always_ff @(posedge clk)
    begin
        if (adv[ST_M])
        begin
            p11_reg <= PW'(cs_reg) * PW'(first_reg[ST_C]);
            p12_reg <= PW'(nsn_reg) * PW'(second_reg[ST_C]);
            p21_reg <= PW'(sn_reg) * PW'(first_reg[ST_C]);
            p22_reg <= PW'(cs_reg) * PW'(second_reg[ST_C]);
        end
    end

    // sum stage with the rounding half added
    always_ff @(posedge clk)
    begin
        if (adv[ST_S])
        begin
            sum1_reg <= SW'(p11_reg) + SW'(p12_reg) + RND_HALF;
            sum2_reg <= SW'(p21_reg) + SW'(p22_reg) + RND_HALF;
        end
    end

    function automatic data_t sat_round(input logic signed [SW-1:0] s);
        logic signed [RW-1:0] t;
        data_t                r;
        begin
            t = signed'(s[SW-1:FRAC_W]);
            if (t > SAT_HI)
            begin
                r = DATA_WIDTH'(SAT_HI);
            end
            else if (t < SAT_LO)
            begin
                r = DATA_WIDTH'(SAT_LO);
            end
            else
            begin
                r = DATA_WIDTH'(t);
            end
            return r;
        end
    endfunction

    // saturate and put the pair back in place
    always_comb
    begin
        data_t r1, r2;
        r1 = sat_round(sum1_reg);
        r2 = sat_round(sum2_reg);
        unique case (plane_reg[ST_S])
            PLANE_XY:
            begin
                rot_x_next = r1;
                rot_y_next = r2;
                rot_z_next = third_reg[ST_S];
            end
            PLANE_YZ:
            begin
                rot_x_next = third_reg[ST_S];
                rot_y_next = r1;
                rot_z_next = r2;
            end
            default:
            begin
                rot_x_next = r2;
                rot_y_next = third_reg[ST_S];
                rot_z_next = r1;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv[ST_O])
        begin
            rot_x_reg <= rot_x_next;
            rot_y_reg <= rot_y_next;
            rot_z_reg <= rot_z_next;
        end
    end

    assign m_tvalid = vld_reg[ST_O];
    assign m_tdata  = OUT_TDATA_W'({rot_z_reg, rot_y_reg, rot_x_reg});

    `VPR_ASSERT_NEXT(a_accept_fills, s_tvalid && s_tready, vld_reg[0],
        "accepted beat did not enter the first stage")
    `VPR_ASSERT_IMPL(a_full_stall, (&vld_reg) && !m_tready, !s_tready,
        "input ready while the pipeline is full and stalled")
    `VPR_ASSERT_IMPL(a_plane_folded, vld_reg[0], plane_reg[0] != PLANE_ALIAS,
        "plane selector three not folded onto plane zero")
    `VPR_ASSERT_IMPL(a_bubble_ready, !(&vld_reg), s_tready,
        "input not ready although a stage is empty")

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// testbench for vector_plane_rotation_top: directed corners then random vectors, with
// random gaps on both stream sides and one long output stall; a cordic predictor checks
// every output beat. depends on vpr_pkg and the rtl of the block
`timescale 1ns / 1ps

module tb_top;
    import vpr_pkg::*;

    typedef logic signed [ANGLE_WIDTH-1:0] angle_t;

    typedef struct {
        data_t rot_x;
        data_t rot_y;
        data_t rot_z;
    } rotated_vec_t;

    localparam int PIPE_LATENCY   = CORDIC_STAGES + 5;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SINK_HOLD      = 200;

    localparam data_t DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam data_t DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam data_t ONE      = 32'sh00010000;

    localparam angle_t ANGLE_MAX = {1'b0, {(ANGLE_WIDTH-1){1'b1}}};
    localparam angle_t ANGLE_MIN = {1'b1, {(ANGLE_WIDTH-1){1'b0}}};

    localparam longint QUARTER_TURN = 64'sd1 << 30;
    localparam longint HALF_TURN    = 64'sd1 << 31;
    localparam longint CORDIC_SEED  = 64'sh26DD3B6A;

    longint atan_bam [0:15] = '{
        64'sh20000000, 64'sh12E4051E, 64'sh09FB385B, 64'sh051111D4,
        64'sh028B0D43, 64'sh0145D7E1, 64'sh00A2F61E, 64'sh00517C55,
        64'sh0028BE53, 64'sh00145F2F, 64'sh000A2F98, 64'sh000517CC,
        64'sh00028BE6, 64'sh000145F3, 64'sh0000A2FA, 64'sh0000517D
    };

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    rotated_vec_t expected_rotations [$];
    rotated_vec_t want;
    int           error_count = 0;
    int           quiet_cycles = 0;
    bit           sink_hold_req = 1'b0;
    bit           sink_steady = 1'b0;

    vector_plane_rotation_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic data_t mix_round(input longint c1, input data_t a1,
                                        input longint c2, input data_t a2);
        logic signed [127:0] wc1, wc2, wa1, wa2, acc;
        wc1 = c1;
        wc2 = c2;
        wa1 = a1;
        wa2 = a2;
        acc = wc1 * wa1 + wc2 * wa2 + (128'sd1 <<< 29);
        acc = acc >>> 30;
        if (acc > 128'sd2147483647)
            return DATA_MAX;
        if (acc < -128'sd2147483648)
            return DATA_MIN;
        return data_t'(acc[DATA_WIDTH-1:0]);
    endfunction

    function automatic rotated_vec_t rotate_in_plane(input data_t cx, cy, cz,
                                                     input plane_t pl, input angle_t ang);
        data_t        comp [AXES];
        data_t        res [AXES];
        longint       az, zr, xr, yr, dx, dy, cs, sn;
        bit           flip;
        int           first, second, third;
        rotated_vec_t r;
        comp[0] = cx;
        comp[1] = cy;
        comp[2] = cz;
        // selector three aliases onto the x,y plane
        first  = (pl == PLANE_ALIAS) ? int'(PLANE_XY) : int'(pl);
        second = (first + 1) % AXES;
        third  = (first + 2) % AXES;
        az   = ang;
        zr   = az * 65536;
        flip = 1'b0;
        if (zr > QUARTER_TURN)
        begin
            zr   = zr - HALF_TURN;
            flip = 1'b1;
        end
        else if (zr < -QUARTER_TURN)
        begin
            zr   = zr + HALF_TURN;
            flip = 1'b1;
        end
        xr = CORDIC_SEED;
        yr = 0;
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            dx = yr >>> i;
            dy = xr >>> i;
            if (zr >= 0)
            begin
                xr = xr - dx;
                yr = yr + dy;
                zr = zr - atan_bam[i];
            end
            else
            begin
                xr = xr + dx;
                yr = yr - dy;
                zr = zr + atan_bam[i];
            end
        end
        cs = flip ? -xr : xr;
        sn = flip ? -yr : yr;
        res[first]  = mix_round(cs, comp[first], -sn, comp[second]);
        res[second] = mix_round(sn, comp[first], cs, comp[second]);
        res[third]  = comp[third];
        r.rot_x = res[0];
        r.rot_y = res[1];
        r.rot_z = res[2];
        return r;
    endfunction

    function automatic logic [IN_TDATA_W-1:0] pack_vector(input data_t cx, cy, cz,
                                                          input plane_t pl, input angle_t ang);
        logic [IN_TDATA_W-1:0] w;
        w = '0;
        w[DATA_WIDTH-1:0]              = cx;
        w[2*DATA_WIDTH-1:DATA_WIDTH]   = cy;
        w[3*DATA_WIDTH-1:2*DATA_WIDTH] = cz;
        w[3*DATA_WIDTH+PLANE_W-1:3*DATA_WIDTH] = pl;
        w[3*DATA_WIDTH+PLANE_W+ANGLE_WIDTH-1:3*DATA_WIDTH+PLANE_W] = ang;
        return w;
    endfunction

    function automatic int random_gap();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll < 10)
            return 0;
        if (roll < 18)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic data_t rand_comp();
        data_t v;
        v = $urandom;
        case ($urandom_range(0, 9))
            4, 5, 6: v = v >>> 10;
            7:       v = v >>> 3;
            8:       v = v[0] ? DATA_MAX : DATA_MIN;
            9:       v = ($urandom_range(0, 2) == 0) ? '0 : (v[0] ? ONE : -ONE);
            default: ;
        endcase
        return v;
    endfunction

    function automatic angle_t rand_angle();
        angle_t a;
        a = angle_t'($urandom);
        if ($urandom_range(0, 7) == 0)
        begin
            case ($urandom_range(0, 6))
                0:       a = '0;
                1:       a = ANGLE_MAX;
                2:       a = ANGLE_MIN;
                3:       a = 16'sd16384;
                4:       a = 16'sd16385;
                5:       a = -16'sd16384;
                default: a = -16'sd16385;
            endcase
        end
        return a;
    endfunction

    task automatic send_vector(input data_t cx, cy, cz, input plane_t pl,
                               input angle_t ang, input int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= pack_vector(cx, cy, cz, pl, ang);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_rotations.push_back(rotate_in_plane(cx, cy, cz, pl, ang));
    endtask

    task automatic send_random(input int gap);
        send_vector(rand_comp(), rand_comp(), rand_comp(), plane_t'($urandom_range(0, 3)),
                    rand_angle(), gap);
    endtask

    task automatic check_corner_values();
        send_vector(DATA_MAX, DATA_MAX, DATA_MAX, PLANE_XY, '0, 0);
        send_vector(DATA_MIN, DATA_MIN, DATA_MIN, PLANE_YZ, '0, 1);
        send_vector('0, '0, '0, PLANE_ZX, ANGLE_MAX, 0);
        send_vector(DATA_MAX, DATA_MIN, ONE, PLANE_XY, ANGLE_MIN, 2);
    endtask

    task automatic check_each_plane();
        send_vector(ONE, 2 * ONE, 3 * ONE, PLANE_XY, 16'sd8192, 0);
        send_vector(ONE, 2 * ONE, 3 * ONE, PLANE_YZ, 16'sd8192, 0);
        send_vector(ONE, 2 * ONE, 3 * ONE, PLANE_ZX, 16'sd8192, 3);
        send_vector(ONE, 2 * ONE, 3 * ONE, PLANE_ALIAS, 16'sd8192, 0);
    endtask

    task automatic check_angle_corners();
        data_t vx, vy, vz;
        vx = ONE + (ONE >>> 1);
        vy = -(ONE >>> 1);
        vz = ONE >>> 2;
        // minus pi, the largest angle and both sides of the quarter-turn fold
        send_vector(vx, vy, vz, PLANE_XY, ANGLE_MIN, 0);
        send_vector(vx, vy, vz, PLANE_XY, ANGLE_MAX, 0);
        send_vector(vx, vy, vz, PLANE_XY, 16'sd16384, 1);
        send_vector(vx, vy, vz, PLANE_XY, 16'sd16385, 0);
        send_vector(vx, vy, vz, PLANE_XY, -16'sd16384, 0);
        send_vector(vx, vy, vz, PLANE_XY, -16'sd16385, 2);
        send_vector(vx, vy, vz, PLANE_XY, '0, 0);
    endtask

    task automatic check_saturation();
        send_vector(DATA_MAX, DATA_MAX, '0, PLANE_XY, 16'sd8192, 0);
        send_vector(DATA_MIN, DATA_MIN, '0, PLANE_XY, 16'sd8192, 0);
        send_vector(ONE, DATA_MAX, DATA_MIN, PLANE_YZ, -16'sd8192, 0);
        send_vector(DATA_MAX, ONE, DATA_MAX, PLANE_ZX, 16'sd8192, 1);
    endtask

    task automatic check_random_stream();
        int burst_left;
        int gap;
        burst_left = 0;
        for (int n = 0; n < 500; n++)
        begin
            if (burst_left > 0)
            begin
                gap = 0;
                burst_left--;
            end
            else
            begin
                if ($urandom_range(0, 39) == 0)
                    burst_left = 20;
                gap = random_gap();
            end
            send_random(gap);
        end
    endtask

    task automatic check_full_rate();
        sink_steady = 1'b1;
        for (int n = 0; n < 100; n++)
            send_random(0);
        sink_steady = 1'b0;
    endtask

    task automatic check_output_stall();
        sink_hold_req = 1'b1;
        for (int n = 0; n < 60; n++)
            send_random(0);
    endtask

    task automatic compare_field(input string name, input data_t exp_val, input data_t act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t %s mismatch: expected %h actual %h", $time, name, exp_val, act_val);
            error_count++;
        end
    endtask

    // output sink
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (sink_hold_req)
            begin
                m_tready <= 1'b0;
                repeat (SINK_HOLD) @(negedge clk);
                sink_hold_req = 1'b0;
            end
            else if (!sink_steady && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat (random_gap()) @(negedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_rotations.size() == 0)
            begin
                $display("%0t unexpected beat: expected none actual %h", $time, m_tdata);
                error_count++;
            end
            else
            begin
                want = expected_rotations.pop_front();
                compare_field("rot_x", want.rot_x, m_tdata[DATA_WIDTH-1:0]);
                compare_field("rot_y", want.rot_y, m_tdata[2*DATA_WIDTH-1:DATA_WIDTH]);
                compare_field("rot_z", want.rot_z, m_tdata[3*DATA_WIDTH-1:2*DATA_WIDTH]);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        check_corner_values();
        check_each_plane();
        check_angle_corners();
        check_saturation();
        check_random_stream();
        check_full_rate();
        check_output_stall();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_rotations.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 4) @(posedge clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
